@@ src/vdr_cam_pkg.sv @@
`timescale 1ns / 1ps
package vdr_cam_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam int IN_DATA_W  = 216;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 128;
    localparam int OUT_USER_W = 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REQ_STEP  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;

    localparam logic [2:0] REG_CAM_X   = 3'd0;
    localparam logic [2:0] REG_CAM_Y   = 3'd1;
    localparam logic [2:0] REG_CAM_ANG = 3'd2;
    localparam logic [2:0] REG_COG_FA  = 3'd3;
    localparam logic [2:0] REG_OFS_VLD = 3'd4;

    localparam logic signed [33:0] CORDIC_START = 34'sh026DD3B6A;
    localparam logic signed [33:0] ONE_Q30      = 34'sh040000000;
    localparam logic signed [33:0] NEG_ONE_Q30  = -34'sh040000000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_STEP_COR,
        ST_STEP_MX,
        ST_STEP_MY,
        ST_HEAD_COR,
        ST_M_OXCH,
        ST_M_OYSH,
        ST_M_OXSH,
        ST_M_OYCH,
        ST_SUMS,
        ST_CAM_COR,
        ST_M_SXCC,
        ST_M_SYSC,
        ST_M_SYCC,
        ST_M_SXSC,
        ST_FIN
    } t_state;

    function automatic logic [31:0] atan_of(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
        logic signed [53:0] hi;
        logic signed [53:0] lo;
        hi = 54'sh7FFFFFFFFFFF;
        lo = -54'sh800000000000;
        if (v > hi) return hi[47:0];
        if (v < lo) return lo[47:0];
        return v[47:0];
    endfunction

endpackage

@@ src/vehicle_dead_reckoning_camera_shift.sv @@
`timescale 1ns / 1ps
// Dead reckoning with the motion vector reported in the camera frame. One input
// beat at a time is taken; s_axis_tready is high only while the block is idle.
// With offset_valid high, a step beat runs a step CORDIC, two step products, a
// heading CORDIC, four offset products, the sums, a camera-angle CORDIC and four
// more products; a clear, load or unused beat skips the step CORDIC and products.
// One iterative CORDIC unit (one rotation per cycle) serves every angle, and one
// shift-add multiplier (one bit of the sine or cosine per cycle) is shared by all
// products. With offset_valid low, the camera transform is skipped: a step beat
// runs only its CORDIC and two products and other beats none. The result sits in
// an output register, so a stalled master side holds only the final write.
module vehicle_dead_reckoning_camera_shift #(
    parameter int CORDIC_STEPS = vdr_cam_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vdr_cam_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [vdr_cam_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // heading_increment, travelled_distance, slip_angle, load_heading,
    // load_disp_x, load_disp_y
    input  logic [vdr_cam_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [vdr_cam_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // delta_x, delta_y, heading_out
    output logic [vdr_cam_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // vector_valid
    output logic [vdr_cam_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    localparam logic [5:0] COR_DONE = 6'(CORDIC_STEPS + 1);
    localparam logic [5:0] MUL_DONE = 6'd32;

    vdr_cam_pkg::t_state r_state, n_state;
    logic [5:0]  r_cnt;

    logic signed [23:0] r_cam_x, r_cam_y, r_cog_fa;
    logic [31:0]        r_cam_ang;
    logic               r_ofs_vld;

    logic [31:0]        r_head;
    logic signed [47:0] r_disp_x, r_disp_y;
    logic [31:0]        r_ang;
    logic signed [23:0] r_dist;

    logic signed [33:0] r_x, r_y, r_z;
    logic               r_flip;
    logic signed [31:0] r_c, r_s;

    logic signed [81:0] r_mc, r_acc;
    logic [31:0]        r_mp;

    logic signed [51:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [47:0] r_sx, r_sy;

    logic               r_ovalid;
    logic signed [47:0] r_odx, r_ody;
    logic [31:0]        r_ohead;
    logic               r_ovv;

    logic        w_accept, w_cor, w_mul, w_done, w_out_free;
    logic [1:0]  w_req;
    logic [31:0] w_head_nx;
    logic signed [24:0] w_ox, w_oy;
    logic [31:0] w_cang;
    logic        w_flip;
    logic [31:0] w_rot;
    logic [4:0]  w_i;
    logic signed [33:0] w_dx, w_dy, w_at;
    logic signed [33:0] w_xc, w_yc;
    logic signed [49:0] w_v;
    logic signed [31:0] w_t;
    logic signed [81:0] w_add, w_acc_nx, w_rnd;
    logic signed [51:0] w_prod;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_req      = s_axis_tuser;
    assign w_head_nx  = r_head + s_axis_tdata[31:0];
    assign w_ox       = 25'(r_cog_fa) - 25'(r_cam_x);
    assign w_oy       = -25'(r_cam_y);
    assign w_out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        w_cor = 1'b0;
        w_mul = 1'b0;
        case (r_state)
            vdr_cam_pkg::ST_STEP_COR, vdr_cam_pkg::ST_HEAD_COR,
            vdr_cam_pkg::ST_CAM_COR: w_cor = 1'b1;
            vdr_cam_pkg::ST_STEP_MX, vdr_cam_pkg::ST_STEP_MY,
            vdr_cam_pkg::ST_M_OXCH, vdr_cam_pkg::ST_M_OYSH,
            vdr_cam_pkg::ST_M_OXSH, vdr_cam_pkg::ST_M_OYCH,
            vdr_cam_pkg::ST_M_SXCC, vdr_cam_pkg::ST_M_SYSC,
            vdr_cam_pkg::ST_M_SYCC, vdr_cam_pkg::ST_M_SXSC: w_mul = 1'b1;
            default: ;
        endcase
        w_done = w_cor ? (r_cnt == COR_DONE) : (w_mul ? (r_cnt == MUL_DONE) : 1'b1);
    end

    // CORDIC
    always_comb begin
        case (r_state)
            vdr_cam_pkg::ST_STEP_COR: w_cang = r_ang;
            vdr_cam_pkg::ST_HEAD_COR: w_cang = r_head;
            default:                  w_cang = r_cam_ang;
        endcase
        w_flip = (w_cang[31:30] == 2'd1) || (w_cang[31:30] == 2'd2);
        w_rot  = w_flip ? (w_cang + 32'h80000000) : w_cang;
        w_i    = 5'(r_cnt - 6'd1);
        w_dx   = r_y >>> w_i;
        w_dy   = r_x >>> w_i;
        w_at   = 34'(vdr_cam_pkg::atan_of(w_i));
        w_xc   = r_x;
        w_yc   = r_y;
        if (w_xc > vdr_cam_pkg::ONE_Q30) w_xc = vdr_cam_pkg::ONE_Q30;
        if (w_xc < vdr_cam_pkg::NEG_ONE_Q30) w_xc = vdr_cam_pkg::NEG_ONE_Q30;
        if (w_yc > vdr_cam_pkg::ONE_Q30) w_yc = vdr_cam_pkg::ONE_Q30;
        if (w_yc < vdr_cam_pkg::NEG_ONE_Q30) w_yc = vdr_cam_pkg::NEG_ONE_Q30;
        if (r_flip) begin
            w_xc = -w_xc;
            w_yc = -w_yc;
        end
    end

    // shift-add multiplier, rounded half up at 2^-30
    always_comb begin
        case (r_state)
            vdr_cam_pkg::ST_STEP_MX: begin w_v = 50'(r_dist); w_t = r_c; end
            vdr_cam_pkg::ST_STEP_MY: begin w_v = 50'(r_dist); w_t = r_s; end
            vdr_cam_pkg::ST_M_OXCH:  begin w_v = 50'(w_ox);   w_t = r_c; end
            vdr_cam_pkg::ST_M_OYSH:  begin w_v = 50'(w_oy);   w_t = r_s; end
            vdr_cam_pkg::ST_M_OXSH:  begin w_v = 50'(w_ox);   w_t = r_s; end
            vdr_cam_pkg::ST_M_OYCH:  begin w_v = 50'(w_oy);   w_t = r_c; end
            vdr_cam_pkg::ST_M_SXCC:  begin w_v = 50'(r_sx);   w_t = r_c; end
            vdr_cam_pkg::ST_M_SYSC:  begin w_v = 50'(r_sy);   w_t = r_s; end
            vdr_cam_pkg::ST_M_SYCC:  begin w_v = 50'(r_sy);   w_t = r_c; end
            default:                 begin w_v = 50'(r_sx);   w_t = r_s; end
        endcase
        w_add    = r_mp[0] ? r_mc : '0;
        w_acc_nx = (r_cnt == MUL_DONE) ? (r_acc - w_add) : (r_acc + w_add);
        w_rnd    = w_acc_nx + 82'sd536870912;
        w_prod   = w_rnd[81:30];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vdr_cam_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_req == vdr_cam_pkg::REQ_STEP) n_state = vdr_cam_pkg::ST_STEP_COR;
                    else if (r_ofs_vld) n_state = vdr_cam_pkg::ST_HEAD_COR;
                    else n_state = vdr_cam_pkg::ST_FIN;
                end
            end
            vdr_cam_pkg::ST_STEP_COR: if (w_done) n_state = vdr_cam_pkg::ST_STEP_MX;
            vdr_cam_pkg::ST_STEP_MX:  if (w_done) n_state = vdr_cam_pkg::ST_STEP_MY;
            vdr_cam_pkg::ST_STEP_MY: begin
                if (w_done) n_state = r_ofs_vld ? vdr_cam_pkg::ST_HEAD_COR
                                                : vdr_cam_pkg::ST_FIN;
            end
            vdr_cam_pkg::ST_HEAD_COR: if (w_done) n_state = vdr_cam_pkg::ST_M_OXCH;
            vdr_cam_pkg::ST_M_OXCH:   if (w_done) n_state = vdr_cam_pkg::ST_M_OYSH;
            vdr_cam_pkg::ST_M_OYSH:   if (w_done) n_state = vdr_cam_pkg::ST_M_OXSH;
            vdr_cam_pkg::ST_M_OXSH:   if (w_done) n_state = vdr_cam_pkg::ST_M_OYCH;
            vdr_cam_pkg::ST_M_OYCH:   if (w_done) n_state = vdr_cam_pkg::ST_SUMS;
            vdr_cam_pkg::ST_SUMS:     n_state = vdr_cam_pkg::ST_CAM_COR;
            vdr_cam_pkg::ST_CAM_COR:  if (w_done) n_state = vdr_cam_pkg::ST_M_SXCC;
            vdr_cam_pkg::ST_M_SXCC:   if (w_done) n_state = vdr_cam_pkg::ST_M_SYSC;
            vdr_cam_pkg::ST_M_SYSC:   if (w_done) n_state = vdr_cam_pkg::ST_M_SYCC;
            vdr_cam_pkg::ST_M_SYCC:   if (w_done) n_state = vdr_cam_pkg::ST_M_SXSC;
            vdr_cam_pkg::ST_M_SXSC:   if (w_done) n_state = vdr_cam_pkg::ST_FIN;
            vdr_cam_pkg::ST_FIN:      if (w_out_free) n_state = vdr_cam_pkg::ST_IDLE;
            default:                  n_state = vdr_cam_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == vdr_cam_pkg::ST_IDLE);
        m_axis_tvalid = r_ovalid;
        m_axis_tdata  = {r_ohead, r_ody, r_odx};
        m_axis_tuser  = r_ovv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vdr_cam_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
            r_cam_x   <= '0;
            r_cam_y   <= '0;
            r_cam_ang <= '0;
            r_cog_fa  <= '0;
            r_ofs_vld <= 1'b0;
            r_head    <= '0;
            r_disp_x  <= '0;
            r_disp_y  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state || !(w_cor || w_mul)) ? 6'd0 : r_cnt + 6'd1;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    vdr_cam_pkg::REG_CAM_X:   r_cam_x   <= i_cfg_wdata[23:0];
                    vdr_cam_pkg::REG_CAM_Y:   r_cam_y   <= i_cfg_wdata[23:0];
                    vdr_cam_pkg::REG_CAM_ANG: r_cam_ang <= i_cfg_wdata;
                    vdr_cam_pkg::REG_COG_FA:  r_cog_fa  <= i_cfg_wdata[23:0];
                    vdr_cam_pkg::REG_OFS_VLD: r_ofs_vld <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (w_accept) begin
                case (w_req)
                    vdr_cam_pkg::REQ_STEP: r_head <= w_head_nx;
                    vdr_cam_pkg::REQ_CLEAR: begin
                        r_head   <= '0;
                        r_disp_x <= '0;
                        r_disp_y <= '0;
                    end
                    vdr_cam_pkg::REQ_LOAD: begin
                        r_head   <= s_axis_tdata[119:88];
                        r_disp_x <= s_axis_tdata[167:120];
                        r_disp_y <= s_axis_tdata[215:168];
                    end
                    default: ;
                endcase
            end

            if (w_mul && w_done) begin
                case (r_state)
                    vdr_cam_pkg::ST_STEP_MX:
                        r_disp_x <= vdr_cam_pkg::sat48(54'(r_disp_x) + 54'(w_prod));
                    vdr_cam_pkg::ST_STEP_MY:
                        r_disp_y <= vdr_cam_pkg::sat48(54'(r_disp_y) + 54'(w_prod));
                    default: ;
                endcase
            end

            if (r_state == vdr_cam_pkg::ST_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ang  <= w_head_nx + s_axis_tdata[87:56];
            r_dist <= s_axis_tdata[55:32];
        end

        if (w_cor) begin
            if (r_cnt == 6'd0) begin
                r_x    <= vdr_cam_pkg::CORDIC_START;
                r_y    <= '0;
                r_z    <= 34'(signed'(w_rot));
                r_flip <= w_flip;
            end else if (r_cnt != COR_DONE) begin
                if (!r_z[33]) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
            end else begin
                r_c <= w_xc[31:0];
                r_s <= w_yc[31:0];
            end
        end

        if (w_mul) begin
            if (r_cnt == 6'd0) begin
                r_mc  <= 82'(w_v);
                r_mp  <= w_t;
                r_acc <= '0;
            end else begin
                r_acc <= w_acc_nx;
                r_mc  <= r_mc <<< 1;
                r_mp  <= r_mp >> 1;
            end
            if (w_done) begin
                case (r_state)
                    vdr_cam_pkg::ST_M_OXCH, vdr_cam_pkg::ST_M_SXCC: r_pa <= w_prod;
                    vdr_cam_pkg::ST_M_OYSH, vdr_cam_pkg::ST_M_SYSC: r_pb <= w_prod;
                    vdr_cam_pkg::ST_M_OXSH, vdr_cam_pkg::ST_M_SYCC: r_pc <= w_prod;
                    vdr_cam_pkg::ST_M_OYCH, vdr_cam_pkg::ST_M_SXSC: r_pd <= w_prod;
                    default: ;
                endcase
            end
        end

        if (r_state == vdr_cam_pkg::ST_SUMS) begin
            r_sx <= vdr_cam_pkg::sat48(54'(r_pa) - 54'(r_pb) + 54'(r_disp_x) - 54'(w_ox));
            r_sy <= vdr_cam_pkg::sat48(54'(r_pc) + 54'(r_pd) + 54'(r_disp_y) - 54'(w_oy));
        end

        if (r_state == vdr_cam_pkg::ST_FIN && w_out_free) begin
            r_ohead <= r_head;
            r_ovv   <= r_ofs_vld;
            if (r_ofs_vld) begin
                r_odx <= vdr_cam_pkg::sat48(54'(r_pa) + 54'(r_pb));
                r_ody <= vdr_cam_pkg::sat48(54'(r_pc) - 54'(r_pd));
            end else begin
                r_odx <= '0;
                r_ody <= '0;
            end
        end
    end

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != vdr_cam_pkg::ST_IDLE)
        else $error("accepted beat did not start work");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'd33)
        else $error("step counter overrun");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == vdr_cam_pkg::ST_FIN)
        else $error("result shown outside final step");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mul || w_cor) |-> !s_axis_tready)
        else $error("input taken while busy");

endmodule
